### hdl/sdf_pkg.sv
// shared types and constants for the stream duplicate filter
// no dependencies; imported by every module of the block

package sdf_pkg;

  localparam int SET_ENTRIES = 64;
  localparam int VALUE_W     = 32;

  // one input beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_list;
  } item_t;

  // one result beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      keep;
    logic                      set_full;
    logic                      out_last;
  } result_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic [VALUE_W-1:0] probe;
    logic               shift;
    logic               clear;
  } cell_ctl_t;

endpackage

### hdl/stream_duplicate_filter_unit.sv
// top level of the stream duplicate filter: cell chain, match reduction, result register
// depends on sdf_pkg and sdf_cell

// Filters one list of signed 32-bit values, one beat per clock cycle while
// item_stall is low, and registers the result beat of an accepted item beat
// in the cycle after it is accepted. The seen-set is a chain of SET_ENTRIES
// cells; every cell compares its stored value with the incoming one in the
// same cycle, and a first occurrence is pushed in at the head of the chain
// while every cell hands its entry to the next one. The rate of one beat per
// cycle is set by that compare and shift across the chain in the same cycle.
// When the chain is full a new value is kept but not stored and set_full is
// raised. After the beat that carries end_of_list the chain is emptied, so
// the next list starts with an empty set. No clearing pass is needed after
// reset. item_stall follows result_stall only while a result beat is waiting.

module stream_duplicate_filter_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sdf_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sdf_pkg::result_t result
);
  import sdf_pkg::*;

  logic                   accept;
  logic                   hit;
  logic                   full;
  cell_ctl_t              ctl;
  logic [VALUE_W-1:0]     chain_value [SET_ENTRIES+1];
  logic                   chain_used  [SET_ENTRIES+1];
  logic [SET_ENTRIES-1:0] match;

  // the result register frees up when empty or when its beat is taken
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // head of the chain: a new entry enters as used
  assign chain_value[0] = item.value;
  assign chain_used[0]  = 1'b1;

  // last cell in use means every cell is in use
  assign full = chain_used[SET_ENTRIES];
  assign hit  = |match;

  // insert only a value not yet seen, and only with room left
  assign ctl.probe = item.value;
  assign ctl.shift = accept && !hit && !full;
  assign ctl.clear = accept && item.end_of_list;

  for (genvar i = 0; i < SET_ENTRIES; i++) begin : g_cell
    sdf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_value (chain_value[i]),
      .prev_used  (chain_used[i]),
      .value      (chain_value[i+1]),
      .used       (chain_used[i+1]),
      .match      (match[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.out_value <= item.value;
      result.keep      <= !hit;
      result.set_full  <= !hit && full;
      result.out_last  <= item.end_of_list;
    end
  end

endmodule

### hdl/sdf_cell.sv
// one entry of the seen-set chain: stored value, used flag, match compare
// depends on sdf_pkg

module sdf_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  sdf_pkg::cell_ctl_t      ctl,
  input  logic [sdf_pkg::VALUE_W-1:0] prev_value,
  input  logic                    prev_used,
  output logic [sdf_pkg::VALUE_W-1:0] value,
  output logic                    used,
  output logic                    match
);
  import sdf_pkg::*;

  // used flag shifts with the value; clear empties the whole row at once
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.clear) begin
      used <= 1'b0;
    end else if (ctl.shift) begin
      used <= prev_used;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= prev_value;
    end
  end

  assign match = used && (value == ctl.probe);

endmodule

### hdl/sdf_chk.sv
// port-level checker for the stream duplicate filter, bound to the top level
// depends on sdf_pkg and stream_duplicate_filter_unit

module sdf_chk (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sdf_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input sdf_pkg::result_t result
);
  import sdf_pkg::*;

  logic accept;
  assign accept = item_valid && !item_stall;

  // every accepted item gives a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("no result beat after accepted item");

  // value and marker pass through unchanged
  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    accept |=> (result.out_value == $past(item.value))
               && (result.out_last == $past(item.end_of_list)))
    else $error("result value or marker differs from item");

  // full flag only on a kept value
  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.set_full) |-> result.keep)
    else $error("set_full on a dropped duplicate");

  // a value repeated back to back inside one list is dropped,
  // unless the first one found the set full and was not stored
  a_repeat_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && !item.end_of_list) ##1
      (accept && (item.value == $past(item.value)) && !result.set_full)
      |=> !result.keep)
    else $error("immediate repeat was kept");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

bind stream_duplicate_filter_unit sdf_chk u_sdf_chk (.*);
